/* hdl/frame_delay_line_overflow_decimator_defines.svh */
// Assertion macros for the frame delay line.
// Depends on signals clk and arst_n in the scope of use.
`ifndef FRAME_DELAY_LINE_OVERFLOW_DECIMATOR_DEFINES_SVH
`define FRAME_DELAY_LINE_OVERFLOW_DECIMATOR_DEFINES_SVH

// same-cycle implication
`define FDL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FDL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/fdl_pkg.sv */
// Shared constants and types for the frame delay line.
// No dependencies.
`timescale 1ns / 1ps

package fdl_pkg;

	localparam int DEPTH   = 16;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W  = $clog2(DEPTH + 1);

	localparam int OP_W    = 2;
	localparam int ID_W    = 29;
	localparam int LEN_W   = 4;
	localparam int PAY_W   = 64;
	localparam int REG_W   = 16;
	localparam int CIDX_W  = 2;

	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_ARM  = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK = 2'd2;

	localparam logic [CIDX_W-1:0] REG_DEFAULT_DIV = 2'd0;
	localparam logic [CIDX_W-1:0] REG_FAST_DIV    = 2'd1;
	localparam logic [CIDX_W-1:0] REG_TIMER_LOAD  = 2'd2;

	localparam logic [REG_W-1:0] RST_DEFAULT_DIV = 16'd8;
	localparam logic [REG_W-1:0] RST_FAST_DIV    = 16'd1;
	localparam logic [REG_W-1:0] RST_TIMER_LOAD  = 16'd1000;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] len;
		logic [PAY_W-1:0] payload;
	} entry_t;

	typedef struct packed {
		logic            accept;
		logic [OP_W-1:0] op;
	} txn_t;

endpackage

/* hdl/fdl_if.sv */
// Channel interfaces: input item, result item and register write.
// Depends on fdl_pkg.
`timescale 1ns / 1ps

interface fdl_in_if;
	logic                        valid;
	logic                        ready;
	logic [fdl_pkg::OP_W-1:0]    op;
	logic [fdl_pkg::ID_W-1:0]    frame_id;
	logic [fdl_pkg::LEN_W-1:0]   frame_len;
	logic [fdl_pkg::PAY_W-1:0]   frame_payload;
	modport source (output valid, op, frame_id, frame_len, frame_payload, input ready);
	modport sink (input valid, op, frame_id, frame_len, frame_payload, output ready);
endinterface

interface fdl_out_if;
	logic                        valid;
	logic                        ready;
	logic                        evicted_valid;
	logic                        send_flag;
	logic [fdl_pkg::ID_W-1:0]    evicted_id;
	logic [fdl_pkg::LEN_W-1:0]   evicted_len;
	logic [fdl_pkg::PAY_W-1:0]   evicted_payload;
	modport source (output valid, evicted_valid, send_flag, evicted_id, evicted_len,
		evicted_payload, input ready);
	modport sink (input valid, evicted_valid, send_flag, evicted_id, evicted_len,
		evicted_payload, output ready);
endinterface

interface fdl_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [fdl_pkg::CIDX_W-1:0]  index;
	logic [fdl_pkg::REG_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/fdl_store.sv */
// Ring store of frames with fill count and registered read of the oldest slot.
// Depends on fdl_pkg.
`timescale 1ns / 1ps

module fdl_store (
	input  logic             clk,
	input  logic             arst_n,
	input  fdl_pkg::txn_t    txn,
	input  fdl_pkg::entry_t  wr_entry,
	output logic             evicted,
	output fdl_pkg::entry_t  rd_entry
);
	import fdl_pkg::*;

	entry_t              mem [DEPTH];
	entry_t              rd_q;
	logic [ADDR_W-1:0]   slot_q;
	logic [FILL_W-1:0]   fill_q;
	logic                push;

	assign push     = txn.accept && (txn.op == OP_PUSH);
	assign evicted  = (fill_q == FILL_W'(DEPTH));
	assign rd_entry = rd_q;

	always_ff @(posedge clk) begin
		if (push) begin
			rd_q <= mem[slot_q];
			mem[slot_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
		end else if (push) begin
			slot_q <= (slot_q == ADDR_W'(DEPTH - 1)) ? '0 : slot_q + ADDR_W'(1);
			if (!evicted) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

endmodule

/* hdl/fdl_cfg.sv */
// Configuration registers, countdown timer and eviction divider.
// Depends on fdl_pkg and fdl_cfg_if.
`timescale 1ns / 1ps

module fdl_cfg (
	input  logic           clk,
	input  logic           arst_n,
	fdl_cfg_if.sink        cfg,
	input  fdl_pkg::txn_t  txn,
	input  logic           evicted,
	output logic           send
);
	import fdl_pkg::*;

	logic [REG_W-1:0] default_div_q;
	logic [REG_W-1:0] fast_div_q;
	logic [REG_W-1:0] timer_load_q;
	logic [REG_W-1:0] evict_cnt_q;
	logic [REG_W-1:0] countdown_q;
	logic [REG_W-1:0] divider;
	logic [REG_W-1:0] cnt_inc;
	logic             count_en;

	assign cfg.ready = 1'b1;
	assign divider   = (countdown_q != '0) ? fast_div_q : default_div_q;
	assign cnt_inc   = evict_cnt_q + REG_W'(1);
	assign count_en  = txn.accept && (txn.op == OP_PUSH) && evicted && (divider != '0);
	assign send      = count_en && (cnt_inc >= divider);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_div_q <= RST_DEFAULT_DIV;
			fast_div_q    <= RST_FAST_DIV;
			timer_load_q  <= RST_TIMER_LOAD;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DEFAULT_DIV: default_div_q <= cfg.data;
				REG_FAST_DIV:    fast_div_q    <= cfg.data;
				REG_TIMER_LOAD:  timer_load_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evict_cnt_q <= '0;
			countdown_q <= '0;
		end else if (txn.accept) begin
			if (count_en) begin
				evict_cnt_q <= send ? '0 : cnt_inc;
			end
			if (txn.op == OP_ARM) begin
				countdown_q <= timer_load_q;
			end else if (txn.op == OP_TICK && countdown_q != '0) begin
				countdown_q <= countdown_q - REG_W'(1);
			end
		end
	end

endmodule

/* hdl/frame_delay_line_overflow_decimator.sv */
// Frame delay line with overflow decimation. Takes one transaction per clock while
// the result channel does not stall, and returns exactly one result per transaction:
// the registered read of the oldest ring slot comes first, then the result
// register. A full ring evicts its oldest frame on every push; evictions are
// decimated by the active divider into send_flag. Register writes take effect
// at once and are never stalled.
`timescale 1ns / 1ps
`include "frame_delay_line_overflow_decimator_defines.svh"

module frame_delay_line_overflow_decimator (
	input  logic       clk,
	input  logic       arst_n,
	fdl_in_if.sink     frame_in,
	fdl_out_if.source  result_out,
	fdl_cfg_if.sink    cfg
);
	import fdl_pkg::*;

	txn_t              txn;
	entry_t            wr_entry;
	entry_t            rd_entry;
	logic              evicted;
	logic              send;
	logic              advance;
	logic              valid_s1;
	logic              evicted_s1;
	logic              send_s1;
	logic              out_valid_q;
	logic              out_evicted_q;
	logic              out_send_q;
	logic [ID_W-1:0]   out_id_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [PAY_W-1:0]  out_pay_q;

	assign advance        = valid_s1 && (!out_valid_q || result_out.ready);
	assign frame_in.ready = !valid_s1 || advance;
	assign txn.accept     = frame_in.valid && frame_in.ready;
	assign txn.op         = frame_in.op;
	assign wr_entry.id      = frame_in.frame_id;
	assign wr_entry.len     = frame_in.frame_len;
	assign wr_entry.payload = frame_in.frame_payload;

	fdl_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.txn      (txn),
		.wr_entry (wr_entry),
		.evicted  (evicted),
		.rd_entry (rd_entry)
	);

	fdl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.txn     (txn),
		.evicted (evicted),
		.send    (send)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			evicted_s1 <= 1'b0;
			send_s1    <= 1'b0;
		end else if (frame_in.ready) begin
			valid_s1   <= frame_in.valid;
			evicted_s1 <= txn.accept && (txn.op == OP_PUSH) && evicted;
			send_s1    <= send;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_evicted_q <= evicted_s1;
			out_send_q    <= send_s1;
			out_id_q      <= evicted_s1 ? rd_entry.id : '0;
			out_len_q     <= evicted_s1 ? rd_entry.len : '0;
			out_pay_q     <= evicted_s1 ? rd_entry.payload : '0;
		end
	end

	assign result_out.valid           = out_valid_q;
	assign result_out.evicted_valid   = out_evicted_q;
	assign result_out.send_flag       = out_send_q;
	assign result_out.evicted_id      = out_id_q;
	assign result_out.evicted_len     = out_len_q;
	assign result_out.evicted_payload = out_pay_q;

	`FDL_ASSERT_NOW(a_send_needs_evict, result_out.valid && result_out.send_flag, result_out.evicted_valid, "send_flag without eviction")
	`FDL_ASSERT_NOW(a_zero_result, result_out.valid && !result_out.evicted_valid, result_out.evicted_id == '0 && result_out.evicted_len == '0 && result_out.evicted_payload == '0, "nonzero fields without eviction")
	`FDL_ASSERT_NOW(a_stall_only_full, !frame_in.ready, valid_s1 && out_valid_q, "input stalled with a free stage")
	`FDL_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1, "stage one lost while stalled")

endmodule

/* dv/fdl_checker.sv */
// Checker for the frame delay line: watches the frame, result and register channels,
// predicts every result from its own copy of the ring and divider state, and compares.
// Depends on fdl_pkg and the channel interfaces in fdl_if.sv.
`timescale 1ns / 1ps

module fdl_checker (
	input  logic clk,
	input  logic arst_n,
	fdl_in_if    frame_in,
	fdl_out_if   result_out,
	fdl_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);
	import fdl_pkg::*;

	typedef struct packed {
		logic             evicted_valid;
		logic             send_flag;
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] len;
		logic [PAY_W-1:0] payload;
	} line_out_t;

	entry_t             line_store [DEPTH];
	logic [FILL_W-1:0]  fill;
	logic [ADDR_W-1:0]  wr_slot;
	logic [REG_W-1:0]   evict_count;
	logic [REG_W-1:0]   countdown;
	logic [REG_W-1:0]   div_default;
	logic [REG_W-1:0]   div_fast;
	logic [REG_W-1:0]   load_value;
	line_out_t          outputs_due [$];
	line_out_t          want;
	entry_t             frame;

	function automatic line_out_t step_delay_line(input logic [OP_W-1:0] op,
		input entry_t pushed);
		line_out_t        res;
		logic [REG_W-1:0] divider;
		res = '0;
		case (op)
			OP_PUSH: begin
				if (fill >= DEPTH) begin
					res.evicted_valid = 1'b1;
					res.id      = line_store[wr_slot].id;
					res.len     = line_store[wr_slot].len;
					res.payload = line_store[wr_slot].payload;
				end else begin
					fill++;
				end
				line_store[wr_slot] = pushed;
				wr_slot = (wr_slot == ADDR_W'(DEPTH - 1)) ? '0 : wr_slot + 1'b1;
				divider = (countdown != '0) ? div_fast : div_default;
				if (divider != '0 && res.evicted_valid) begin
					evict_count++;
					if (evict_count >= divider) begin
						evict_count = '0;
						res.send_flag = 1'b1;
					end
				end
			end
			OP_ARM: begin
				countdown = load_value;
			end
			OP_TICK: begin
				if (countdown != '0)
					countdown--;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic check_field(input string name, input logic [63:0] expected,
		input logic [63:0] actual);
		if (expected !== actual) begin
			fail_count++;
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
				$time, name, expected, actual);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill        = '0;
			wr_slot     = '0;
			evict_count = '0;
			countdown   = '0;
			div_default = RST_DEFAULT_DIV;
			div_fast    = RST_FAST_DIV;
			load_value  = RST_TIMER_LOAD;
			outputs_due.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_DEFAULT_DIV: div_default = cfg.data;
					REG_FAST_DIV:    div_fast    = cfg.data;
					REG_TIMER_LOAD:  load_value  = cfg.data;
					default: begin
					end
				endcase
			end
			if (frame_in.valid && frame_in.ready) begin
				frame.id      = frame_in.frame_id;
				frame.len     = frame_in.frame_len;
				frame.payload = frame_in.frame_payload;
				outputs_due.push_back(step_delay_line(frame_in.op, frame));
			end
			if (result_out.valid && result_out.ready) begin
				if (outputs_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result: expected none, actual id 0x%0h valid %0b",
						$time, result_out.evicted_id, result_out.evicted_valid);
				end else begin
					want = outputs_due.pop_front();
					check_field("evicted_valid", want.evicted_valid, result_out.evicted_valid);
					check_field("send_flag", want.send_flag, result_out.send_flag);
					check_field("evicted_id", want.id, result_out.evicted_id);
					check_field("evicted_len", want.len, result_out.evicted_len);
					check_field("evicted_payload", want.payload, result_out.evicted_payload);
				end
			end
		end
		pending = outputs_due.size();
	end

endmodule

/* dv/testbench.sv */
// Top of the frame delay line testbench: clock, reset, frame and register stimulus,
// random backpressure on the result channel, and the final verdict.
// Depends on fdl_pkg, fdl_if.sv, fdl_checker and the block itself.
`timescale 1ns / 1ps

module testbench;
	import fdl_pkg::*;

	localparam logic [OP_W-1:0]   OP_UNUSED      = 2'd3;
	localparam logic [CIDX_W-1:0] REG_UNUSED     = 2'd3;
	localparam int                PHASES         = 8;
	localparam int                ITEMS_PER_PHASE = 142;
	localparam int                CYCLE_LIMIT    = 200000;

	logic clk = 1'b0;
	logic arst_n;
	logic idle_on = 1'b1;
	int   fail_count;
	int   pending;
	int   stall_left = 0;
	int   cycle_count;

	fdl_in_if  frame_in ();
	fdl_out_if result_out ();
	fdl_cfg_if cfg ();

	frame_delay_line_overflow_decimator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_in   (frame_in),
		.result_out (result_out),
		.cfg        (cfg)
	);

	fdl_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_in   (frame_in),
		.result_out (result_out),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// stall the result channel in bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_out.ready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			result_out.ready <= 1'b0;
			stall_left = $urandom_range(0, 7);
		end else begin
			result_out.ready <= 1'b1;
		end
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
		input logic [LEN_W-1:0] len, input logic [PAY_W-1:0] payload);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
		@(negedge clk);
		if (gap > 0) begin
			frame_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		frame_in.valid         <= 1'b1;
		frame_in.op            <= op;
		frame_in.frame_id      <= id;
		frame_in.frame_len     <= len;
		frame_in.frame_payload <= payload;
		@(posedge clk);
		while (!frame_in.ready) @(posedge clk);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		frame_in.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [REG_W-1:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int               r;
		int               pick;
		logic [OP_W-1:0]  op;
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] len;
		logic [PAY_W-1:0] payload;
		logic [REG_W-1:0] d_div;
		logic [REG_W-1:0] f_div;
		logic [REG_W-1:0] load;

		arst_n                 = 1'b0;
		frame_in.valid         = 1'b0;
		frame_in.op            = OP_PUSH;
		frame_in.frame_id      = '0;
		frame_in.frame_len     = '0;
		frame_in.frame_payload = '0;
		result_out.ready       = 1'b0;
		cfg.valid              = 1'b0;
		cfg.index              = REG_DEFAULT_DIV;
		cfg.data               = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset dividers, tick while stopped, unused op, fill, evict
		send_item(OP_TICK, '0, '0, '0);
		send_item(OP_UNUSED, '1, '1, '1);
		for (int i = 0; i < DEPTH; i++)
			send_item(OP_PUSH, i[0] ? '1 : ID_W'(i * 7), LEN_W'(i),
				i[0] ? '1 : {32'(i), 32'h5A5A_A5A5});
		send_item(OP_PUSH, 29'h0AAA_AAAA, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA);
		send_item(OP_PUSH, 29'h1555_5555, 4'd0, 64'h5555_5555_5555_5555);
		send_item(OP_ARM, '0, '0, '0);
		send_item(OP_PUSH, '0, 4'd8, '0);
		send_item(OP_PUSH, '1, 4'd15, '1);
		wait_idle();
		write_reg(REG_TIMER_LOAD, '0);
		send_item(OP_ARM, '0, '0, '0);
		send_item(OP_PUSH, 29'h0123_4567, 4'd3, 64'h0123_4567_89AB_CDEF);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin d_div = 16'd2;     f_div = 16'd1;     load = 16'd12;    end
				1: begin d_div = 16'd0;     f_div = 16'd3;     load = 16'd20;    end
				2: begin d_div = 16'hFFFF;  f_div = 16'd0;     load = 16'd8;     end
				3: begin d_div = 16'd1;     f_div = 16'hFFFF;  load = 16'hFFFF;  end
				4: begin
					d_div = REG_W'($urandom_range(1, 6));
					f_div = REG_W'($urandom_range(1, 6));
					load  = REG_W'($urandom_range(1, 30));
				end
				5: begin d_div = 16'd4;     f_div = 16'd2;     load = 16'd0;     end
				6: begin
					d_div = REG_W'($urandom);
					f_div = REG_W'($urandom);
					load  = REG_W'($urandom_range(1, 40));
				end
				default: begin d_div = 16'd3; f_div = 16'd1; load = 16'd16; end
			endcase
			wait_idle();
			write_reg(REG_DEFAULT_DIV, d_div);
			write_reg(REG_FAST_DIV, f_div);
			write_reg(REG_TIMER_LOAD, load);
			write_reg(REG_UNUSED, REG_W'($urandom));
			idle_on = (ph != PHASES - 1);

			repeat (ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					op = OP_PUSH;
				else if (r < 70)
					op = OP_ARM;
				else if (r < 95)
					op = OP_TICK;
				else
					op = OP_UNUSED;
				pick    = $urandom_range(0, 15);
				id      = ID_W'($urandom);
				payload = {$urandom, $urandom};
				if (pick == 0)
					id = '0;
				else if (pick == 1)
					id = '1;
				else if (pick == 2)
					payload = '0;
				else if (pick == 3)
					payload = '1;
				len = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(9, 15))
					: LEN_W'($urandom_range(0, 8));
				send_item(op, id, len, payload);
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
